// ===== sv/b32d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the Bech32/Bech32m string decoder.
// No dependencies; imported by every module of the block.
package b32d_pkg;

  // Width of the polymod checksum register
  localparam int unsigned CHK_W = 30;
  // Number of trailing checksum symbols held back from the output
  localparam int unsigned CHECK_SYMBOLS = 6;
  localparam int unsigned FILL_W = $clog2(CHECK_SYMBOLS + 1);

  // String length limits
  localparam logic [9:0] LEN_MIN = 10'd8;
  localparam logic [9:0] LEN_CAP = 10'd1023;

  // Final residues for the two encodings
  localparam logic [CHK_W-1:0] RESIDUE_BECH32  = 30'h0000_0001;
  localparam logic [CHK_W-1:0] RESIDUE_BECH32M = 30'h2bc8_30a3;

  // Result status codes
  localparam logic [1:0] STATUS_BECH32  = 2'd0;
  localparam logic [1:0] STATUS_BECH32M = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // Result kinds
  localparam logic KIND_PREFIX = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // Separator character and printable range for prefix characters
  localparam logic [7:0] CHAR_SEP = 8'h31;
  localparam logic [7:0] CHAR_LO  = 8'd33;
  localparam logic [7:0] CHAR_HI  = 8'd126;

  // BCH generator terms, one per bit of the top symbol
  localparam logic [CHK_W-1:0] GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  typedef logic [4:0] sym_t;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5a);
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= 8'h61) && (b <= 8'h7a);
  endfunction

  // Reverse charset: {bad, symbol}; bad is set for bytes outside the alphabet
  function automatic logic [5:0] sym_lookup(input logic [7:0] b);
    logic [7:0] lc;
    logic [5:0] r;
    lc = is_upper(b) ? (b + 8'd32) : b;
    case (lc)
      8'h71: r = 6'd0;   8'h70: r = 6'd1;   8'h7a: r = 6'd2;   8'h72: r = 6'd3;
      8'h79: r = 6'd4;   8'h39: r = 6'd5;   8'h78: r = 6'd6;   8'h38: r = 6'd7;
      8'h67: r = 6'd8;   8'h66: r = 6'd9;   8'h32: r = 6'd10;  8'h74: r = 6'd11;
      8'h76: r = 6'd12;  8'h64: r = 6'd13;  8'h77: r = 6'd14;  8'h30: r = 6'd15;
      8'h73: r = 6'd16;  8'h33: r = 6'd17;  8'h6a: r = 6'd18;  8'h6e: r = 6'd19;
      8'h35: r = 6'd20;  8'h34: r = 6'd21;  8'h6b: r = 6'd22;  8'h68: r = 6'd23;
      8'h63: r = 6'd24;  8'h65: r = 6'd25;  8'h36: r = 6'd26;  8'h6d: r = 6'd27;
      8'h75: r = 6'd28;  8'h61: r = 6'd29;  8'h37: r = 6'd30;  8'h6c: r = 6'd31;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/bech32_string_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the streaming Bech32/Bech32m string decoder: sequencer, state
// and output register. Depends on b32d_pkg, b32d_poly and b32d_pmem.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid / in_stall    | in_char_byte, in_is_last
//  out     | output    | out_valid / out_stall  | out_kind, out_value, out_value_valid,
//          |           |                        | out_done_res, out_status
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_max_length
//
// A byte goes through accept, execute and finish steps on the shared polymod unit.
// The separator adds a walk step per stored prefix character, as the single read port
// of the prefix store is walked through the same unit. With a result to load, the
// finish step waits while the output register holds an untaken transaction.
// rst_n is synchronous, active low; it clears control and string state, and
// sets max_length to 90. The prefix store needs no clearing pass.
module bech32_string_decoder
  import b32d_pkg::*;
#(
  parameter int unsigned PREFIX_MAX = 84
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_is_last,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [6:0] out_value,
  output logic       out_value_valid,
  output logic       out_done_res,
  output logic [1:0] out_status,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_max_length
);

  localparam int unsigned CW = $clog2(PREFIX_MAX + 1);
  localparam int unsigned AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // String phases
  localparam logic PH_PREFIX = 1'b0;
  localparam logic PH_DATA   = 1'b1;

  logic [1:0]       state_r, state_nxt;
  logic             phase_r, phase_nxt;
  logic [CHK_W-1:0] chk_r, chk_nxt;
  logic [CW-1:0]    pcount_r, pcount_nxt;
  logic [CW-1:0]    walk_r, walk_nxt;
  logic [9:0]       total_r, total_nxt;
  logic             lower_r, lower_nxt;
  logic             upper_r, upper_nxt;
  logic             failed_r, failed_nxt;
  logic [9:0]       maxlen_r;

  logic [7:0]       byte_r;
  logic             last_r;
  logic             hval_r, hval_nxt;
  logic             kind_r, kind_nxt;
  logic [6:0]       val_r, val_nxt;

  sym_t             dly_r [CHECK_SYMBOLS];
  sym_t             dly_nxt [CHECK_SYMBOLS];
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic             ov_r, ov_nxt;
  logic             o_kind_r, o_vv_r, o_done_r;
  logic [6:0]       o_val_r;
  logic [1:0]       o_status_r;
  logic             o_load;

  // Shared unit operands
  sym_t             fold;
  logic [CHK_W-1:0] poly_out;

  // Prefix store ports
  logic             wr_en;
  sym_t             rd_data;

  // Decode of the latched byte
  logic [7:0]       lc_byte;
  logic [5:0]       sym_res;
  logic [1:0]       status;
  logic             in_acc;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign lc_byte = is_upper(byte_r) ? (byte_r + 8'd32) : byte_r;
  assign sym_res = sym_lookup(byte_r);

  b32d_poly u_poly (
    .chk_in  (chk_r),
    .fold    (fold),
    .chk_out (poly_out)
  );

  b32d_pmem #(
    .DEPTH (PREFIX_MAX),
    .AW    (AW)
  ) u_pmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pcount_r[AW-1:0]),
    .wr_data (lc_byte[4:0]),
    .rd_addr (walk_nxt[AW-1:0]),
    .rd_data (rd_data)
  );

  // Final status from the string state
  always_comb begin
    if (failed_r || (phase_r != PH_DATA) || (total_r < LEN_MIN) ||
        (total_r > maxlen_r) || (lower_r && upper_r)) begin
      status = STATUS_INVALID;
    end else if (chk_r == RESIDUE_BECH32) begin
      status = STATUS_BECH32;
    end else if (chk_r == RESIDUE_BECH32M) begin
      status = STATUS_BECH32M;
    end else begin
      status = STATUS_INVALID;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    chk_nxt    = chk_r;
    pcount_nxt = pcount_r;
    walk_nxt   = walk_r;
    total_nxt  = total_r;
    lower_nxt  = lower_r;
    upper_nxt  = upper_r;
    failed_nxt = failed_r;
    hval_nxt   = hval_r;
    kind_nxt   = kind_r;
    val_nxt    = val_r;
    dly_nxt    = dly_r;
    fill_nxt   = fill_r;
    fold       = '0;
    wr_en      = 1'b0;
    o_load     = 1'b0;
    ov_nxt     = ov_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (total_r >= LEN_CAP) begin
            failed_nxt = 1'b1;
          end else begin
            total_nxt = total_r + 10'd1;
          end
          lower_nxt = lower_r || is_lower(in_char_byte);
          upper_nxt = upper_r || is_upper(in_char_byte);
          hval_nxt  = 1'b0;
          kind_nxt  = KIND_PREFIX;
          val_nxt   = '0;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_FIN;
        if (!failed_r) begin
          if (phase_r == PH_PREFIX) begin
            if (byte_r == CHAR_SEP) begin
              // Fold a zero, then walk the stored low bits
              chk_nxt   = poly_out;
              phase_nxt = PH_DATA;
              walk_nxt  = '0;
              if (pcount_r != '0) begin
                state_nxt = ST_WALK;
              end
            end else if ((byte_r < CHAR_LO) || (byte_r > CHAR_HI) ||
                         (pcount_r >= CW'(PREFIX_MAX))) begin
              failed_nxt = 1'b1;
            end else begin
              fold       = {2'b0, lc_byte[7:5]};
              chk_nxt    = poly_out;
              wr_en      = 1'b1;
              pcount_nxt = pcount_r + CW'(1);
              hval_nxt   = 1'b1;
              kind_nxt   = KIND_PREFIX;
              val_nxt    = lc_byte[6:0];
            end
          end else begin
            if (sym_res[5]) begin
              failed_nxt = 1'b1;
            end else begin
              fold    = sym_res[4:0];
              chk_nxt = poly_out;
              if (fill_r >= FILL_W'(CHECK_SYMBOLS)) begin
                // Delay full: oldest symbol goes out
                hval_nxt = 1'b1;
                kind_nxt = KIND_DATA;
                val_nxt  = {2'b0, dly_r[0]};
                for (int i = 0; i < CHECK_SYMBOLS - 1; i++) begin
                  dly_nxt[i] = dly_r[i+1];
                end
                dly_nxt[CHECK_SYMBOLS-1] = sym_res[4:0];
              end else begin
                dly_nxt[fill_r] = sym_res[4:0];
                fill_nxt        = fill_r + FILL_W'(1);
              end
            end
          end
        end
      end

      ST_WALK: begin
        fold    = rd_data;
        chk_nxt = poly_out;
        if ((walk_r + CW'(1)) == pcount_r) begin
          state_nxt = ST_FIN;
        end else begin
          walk_nxt = walk_r + CW'(1);
        end
      end

      ST_FIN: begin
        if (!hval_r && !last_r) begin
          state_nxt = ST_IDLE;
        end else if (!ov_r || !out_stall) begin
          o_load    = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
          if (last_r) begin
            // Back to the start of a new string
            phase_nxt  = PH_PREFIX;
            chk_nxt    = RESIDUE_BECH32;
            pcount_nxt = '0;
            total_nxt  = '0;
            lower_nxt  = 1'b0;
            upper_nxt  = 1'b0;
            fill_nxt   = '0;
            failed_nxt = 1'b0;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_PREFIX;
      chk_r    <= RESIDUE_BECH32;
      pcount_r <= '0;
      walk_r   <= '0;
      total_r  <= '0;
      lower_r  <= 1'b0;
      upper_r  <= 1'b0;
      failed_r <= 1'b0;
      fill_r   <= '0;
      ov_r     <= 1'b0;
      maxlen_r <= 10'd90;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      chk_r    <= chk_nxt;
      pcount_r <= pcount_nxt;
      walk_r   <= walk_nxt;
      total_r  <= total_nxt;
      lower_r  <= lower_nxt;
      upper_r  <= upper_nxt;
      failed_r <= failed_nxt;
      fill_r   <= fill_nxt;
      ov_r     <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        maxlen_r <= cfg_max_length;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_char_byte;
      last_r <= in_is_last;
    end
    hval_r <= hval_nxt;
    kind_r <= kind_nxt;
    val_r  <= val_nxt;
    dly_r  <= dly_nxt;
    if (o_load) begin
      o_kind_r   <= hval_r ? kind_r : 1'b0;
      o_val_r    <= hval_r ? val_r : 7'd0;
      o_vv_r     <= hval_r;
      o_done_r   <= last_r;
      o_status_r <= last_r ? status : STATUS_BECH32;
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = o_kind_r;
  assign out_value       = o_val_r;
  assign out_value_valid = o_vv_r;
  assign out_done_res    = o_done_r;
  assign out_status      = o_status_r;

endmodule

// ===== sv/b32d_poly.sv =====
`timescale 1ns / 1ps
// Shared polymod step unit: one BCH step of the checksum plus a 5-bit fold-in.
// Depends on b32d_pkg.
module b32d_poly
  import b32d_pkg::*;
(
  input  logic [CHK_W-1:0] chk_in,
  input  sym_t             fold,
  output logic [CHK_W-1:0] chk_out
);

  logic [4:0]       top;
  logic [CHK_W-1:0] acc;

  // Shift by one symbol, then xor in the generator terms picked by the top symbol
  always_comb begin
    top = chk_in[CHK_W-1 -: 5];
    acc = {chk_in[CHK_W-6:0], 5'b0};
    for (int i = 0; i < 5; i++) begin
      if (top[i]) begin
        acc = acc ^ GEN[i];
      end
    end
    chk_out = acc ^ {{(CHK_W-5){1'b0}}, fold};
  end

endmodule

// ===== sv/b32d_pmem.sv =====
`timescale 1ns / 1ps
// Prefix store: low five bits of each prefix character, one write and one
// registered read port. Depends on b32d_pkg.
module b32d_pmem
  import b32d_pkg::*;
#(
  parameter int unsigned DEPTH = 84,
  parameter int unsigned AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  sym_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output sym_t          rd_data
);

  sym_t mem [DEPTH];
  sym_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
